@@ hw/rtl/sfd_pkg.sv @@
// Shared types and constants for the sensor frame deframer.
`default_nettype none
package sfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int MAXLEN_W = 10;
  localparam int WIDX_W   = 9;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [BYTE_W-1:0]   SIG_FIRST_RST    = 8'd66;
  localparam logic [BYTE_W-1:0]   SIG_SECOND_RST   = 8'd77;
  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST   = 10'd56;
  localparam logic [WIDX_W-1:0]   WORDS_WANTED_RST = 9'd13;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIG_FIRST    = 2'd0,
    CFG_SIG_SECOND   = 2'd1,
    CFG_MAX_LENGTH   = 2'd2,
    CFG_WORDS_WANTED = 2'd3
  } cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SIG = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_SUM_ERR = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    PH_HUNT   = 8'b0000_0001,
    PH_SIG2   = 8'b0000_0010,
    PH_LEN_HI = 8'b0000_0100,
    PH_LEN_LO = 8'b0000_1000,
    PH_DAT_HI = 8'b0001_0000,
    PH_DAT_LO = 8'b0010_0000,
    PH_CK_HI  = 8'b0100_0000,
    PH_CK_LO  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   sig_first;
    logic [BYTE_W-1:0]   sig_second;
    logic [MAXLEN_W-1:0] max_length;
    logic [WIDX_W-1:0]   words_wanted;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_value;
    status_t           status;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/sfd_if.sv @@
// Valid/ready channel interfaces for received bytes and parsed items.
`default_nettype none
interface sfd_in_if import sfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if import sfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WIDX_W-1:0] word_index;
  logic [WORD_W-1:0] word_value;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, output kind, output word_index, output word_value,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input word_index, input word_value,
                  input status, input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sensor_frame_deframer.sv @@
// Sensor frame deframer top level: config registers, input and output registers.
//
// Usage:
//   in_ch  : received serial bytes, one per item (valid/ready).
//   out_ch : parsed items. kind 0 is a data word with its index; kind 1 is
//            the frame status (ok, bad signature, bad length, sum error)
//            with last set. At most one item per byte.
//   cfg_*  : write-only registers (sig_first, sig_second, max_length,
//            words_wanted). Write them only while the block is idle.
// Path: byte register, then the parse step, then the item register, then out_ch.
// Throughput: one byte per cycle while out_ch is ready; the byte register
//   and item register each pass one entry per cycle; parsing is combinational.
// Stall: while out_ch is held off with an item waiting, one more byte is
//   taken into the byte register, then in_ch.ready drops until out_ch drains.
// Reset (rst_n low, synchronous): both registers empty, parser hunts for
//   the first signature byte, config registers return to 66, 77, 56, 13.
`default_nettype none
module sensor_frame_deframer import sfd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sfd_in_if.sink                     in_ch,
  sfd_out_if.source                  out_ch
);

  cfg_t              cfg_r;
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              fire;
  res_t              res;
  res_t              out_r;

  // Parse step runs when a byte is held and the item register can take a result.
  assign fire        = in_vld_r && (!out_r.valid || out_ch.ready);
  assign in_ch.ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sig_first    <= SIG_FIRST_RST;
      cfg_r.sig_second   <= SIG_SECOND_RST;
      cfg_r.max_length   <= MAX_LENGTH_RST;
      cfg_r.words_wanted <= WORDS_WANTED_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIG_FIRST:    cfg_r.sig_first    <= cfg_data[BYTE_W-1:0];
        CFG_SIG_SECOND:   cfg_r.sig_second   <= cfg_data[BYTE_W-1:0];
        CFG_MAX_LENGTH:   cfg_r.max_length   <= cfg_data[MAXLEN_W-1:0];
        CFG_WORDS_WANTED: cfg_r.words_wanted <= cfg_data[WIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  sfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (fire) begin
      out_r.valid <= res.valid;
    end else if (out_ch.ready) begin
      out_r.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_r.kind       <= res.kind;
      out_r.word_index <= res.word_index;
      out_r.word_value <= res.word_value;
      out_r.status     <= res.status;
      out_r.last       <= res.last;
    end
  end

  assign out_ch.valid      = out_r.valid;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.word_index = out_r.word_index;
  assign out_ch.word_value = out_r.word_value;
  assign out_ch.status     = out_r.status;
  assign out_ch.last       = out_r.last;

`ifndef SYNTHESIS
  a_byte_held_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !fire) |=> (in_vld_r && $stable(in_byte_r)))
    else $error("held byte lost while output stalled");

  a_no_step_into_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_r.valid && !out_ch.ready) |-> !fire)
    else $error("parse step fired into a stalled item register");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/sfd_parser.sv @@
// Frame parse state machine: one byte per step, at most one item out.
`default_nettype none
module sfd_parser import sfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire cfg_t              cfg,
  output res_t                   res
);

  phase_t              phase_r, phase_nxt;
  logic [WORD_W-1:0]   sum_r, sum_nxt;
  logic [MAXLEN_W-1:0] left_r, left_nxt;
  logic [BYTE_W-1:0]   hold_r, hold_nxt;
  logic [WIDX_W-1:0]   wcnt_r, wcnt_nxt;

  logic [WORD_W-1:0]   word;
  logic [WORD_W-1:0]   sum_add;
  logic [MAXLEN_W-1:0] left_dec;
  logic                len_bad;

  assign word     = {hold_r, rx_byte};
  assign sum_add  = sum_r + {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
  assign left_dec = (left_r >= MAXLEN_W'(2)) ? left_r - MAXLEN_W'(2) : '0;
  assign len_bad  = word[0] || (word < WORD_W'(2)) ||
                    (word > {{(WORD_W-MAXLEN_W){1'b0}}, cfg.max_length});

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    hold_nxt  = hold_r;
    wcnt_nxt  = wcnt_r;
    res       = '{valid: 1'b0, kind: KIND_DATA, word_index: '0, word_value: '0,
                  status: ST_OK, last: 1'b0};
    if (step_en) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == cfg.sig_first) begin
            sum_nxt   = {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
            wcnt_nxt  = '0;
            phase_nxt = PH_SIG2;
          end
        end
        PH_SIG2: begin
          if (rx_byte != cfg.sig_second) begin
            phase_nxt  = PH_HUNT;
            res.valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_BAD_SIG;
            res.last   = 1'b1;
          end else begin
            sum_nxt   = sum_add;
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          hold_nxt  = rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          sum_nxt = sum_add;
          if (len_bad) begin
            phase_nxt  = PH_HUNT;
            res.valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_BAD_LEN;
            res.last   = 1'b1;
          end else begin
            left_nxt  = word[MAXLEN_W-1:0];
            phase_nxt = (word[MAXLEN_W-1:0] == MAXLEN_W'(2)) ? PH_CK_HI : PH_DAT_HI;
          end
        end
        PH_DAT_HI: begin
          hold_nxt  = rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_DAT_LO;
        end
        PH_DAT_LO: begin
          sum_nxt = sum_add;
          if (wcnt_r < cfg.words_wanted) begin
            res.valid      = 1'b1;
            res.word_index = wcnt_r;
            res.word_value = word;
          end
          wcnt_nxt  = wcnt_r + WIDX_W'(1);
          left_nxt  = left_dec;
          phase_nxt = (left_dec <= MAXLEN_W'(2)) ? PH_CK_HI : PH_DAT_HI;
        end
        PH_CK_HI: begin
          hold_nxt  = rx_byte;
          phase_nxt = PH_CK_LO;
        end
        PH_CK_LO: begin
          phase_nxt      = PH_HUNT;
          res.valid      = 1'b1;
          res.kind       = KIND_STATUS;
          res.word_value = word;
          res.status     = (word == sum_r) ? ST_OK : ST_SUM_ERR;
          res.last       = 1'b1;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= '0;
      left_r  <= '0;
      hold_r  <= '0;
      wcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      left_r  <= left_nxt;
      hold_r  <= hold_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_res_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> step_en)
    else $error("parser produced an item without a byte");

  a_data_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == KIND_DATA) |-> (res.word_index < cfg.words_wanted))
    else $error("data word index beyond words_wanted");

  a_checksum_from_ck_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == KIND_STATUS &&
     (res.status == ST_OK || res.status == ST_SUM_ERR)) |-> (phase_r == PH_CK_LO))
    else $error("checksum status outside checksum phase");

  a_hunt_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == KIND_STATUS) |=> (phase_r == PH_HUNT))
    else $error("parser did not return to hunting after frame end");
`endif

endmodule
`default_nettype wire
